// File: rtl/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg: shared types and constants of the sparse coordinate store
// Action and status codes, field widths, payload packing and the entry type.
// ----------------------------------------------------------------------------
package scs_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned MAX_DIM_DEF  = 256;
  localparam int unsigned LIM_W        = 9;
  localparam int unsigned IDX_W        = 8;
  localparam int unsigned VAL_W        = 32;

  localparam logic [2:0] ACT_CLEAR = 3'd0;
  localparam logic [2:0] ACT_INS   = 3'd1;
  localparam logic [2:0] ACT_ADD   = 3'd2;
  localparam logic [2:0] ACT_SUB   = 3'd3;
  localparam logic [2:0] ACT_LOOK  = 3'd4;
  localparam logic [2:0] ACT_TRANS = 3'd5;
  localparam logic [2:0] ACT_DUMP  = 3'd6;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_PRESENT  = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic CFG_ROW = 1'b0;
  localparam logic CFG_COL = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] val;
  } entry_t;

  // Per-cell command issued by the controller.
  typedef struct packed {
    logic   shift_in;   // push new entry at head, cells shift toward tail
    logic   remove;     // close the gap at the matched cell
    logic   update;     // write new value into the matched cell
    logic   rotate;     // dump: rotate the chain by one
    entry_t head;
  } cell_cmd_t;

endpackage

// File: rtl/sparse_coordinate_store.sv
// ----------------------------------------------------------------------------
// sparse_coordinate_store: sparse matrix held as a coordinate list
// A chain of cells stores entries newest first; a controller sequences actions.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake              | Payload
// s_axis  | in        | s_axis_tvalid/tready   | tdata: action,row,col,value
// m_axis  | out       | m_axis_tvalid/tready   | tdata: status,row,col,value; tlast
// cfg     | in        | cfg_valid_i/cfg_ready_o| index, data
// Single-result actions go from transfer to result in order (register the
// command, compare across all cells in parallel, update and emit); a new
// transfer is taken only after the result is emitted. The emit step waits
// while an earlier result is still held by m_axis_tready low, and the input
// waits meanwhile. Dump registers the command and compares, then rotates the
// chain one cell per result: one entry per cycle, stalled by m_axis_tready.
// Reset clears the entry count and transpose flag; stored entries are left
// undefined and never read past the count.
// ----------------------------------------------------------------------------
module sparse_coordinate_store #(
  parameter int unsigned CAPACITY = scs_pkg::CAPACITY_DEF,
  parameter int unsigned MAX_DIM  = scs_pkg::MAX_DIM_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // action[2:0], row_index[10:3], column_index[18:11], entry_value[50:19], zero
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], out_row[10:3], out_column[18:11], out_value[50:19], zero
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [scs_pkg::LIM_W-1:0] cfg_data_i
);
  import scs_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned CW    = (DIM_W > LIM_W) ? DIM_W : LIM_W;
  localparam logic [CW-1:0] MAXD = CW'(MAX_DIM);

  typedef enum logic [2:0] {S_IDLE, S_CMP, S_EXEC, S_DUMP, S_OUT} state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  cnt_q, dump_left_q;
  logic              trans_q;
  logic [LIM_W-1:0]  rlim_cfg_q, clim_cfg_q;
  logic [2:0]        act_q;
  logic [IDX_W-1:0]  r_q, c_q;
  logic [VAL_W-1:0]  x_q;
  logic [CAPACITY-1:0] hit_q;
  logic              found_q;
  entry_t            hit_ent_q;
  logic              ov_q, olast_q;
  logic [2:0]        ost_q;
  logic [IDX_W-1:0]  orow_q, ocol_q;
  logic [VAL_W-1:0]  oval_q;

  cell_cmd_t         cmd;
  entry_t            ent [CAPACITY];
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] past;

  logic [IDX_W-1:0] pr, pc;
  assign pr = trans_q ? c_q : r_q;
  assign pc = trans_q ? r_q : c_q;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      entry_t prv, nxt;
      if (g == 0) begin : g_h
        assign prv = cmd.head;
      end else begin : g_m
        assign prv = ent[g-1];
      end
      // During a dump rotation the last live cell takes the head entry.
      if (g == CAPACITY - 1) begin : g_t
        assign nxt = (cmd.rotate && cnt_q == CNT_W'(g + 1)) ? ent[0] : ent[g];
      end else begin : g_n
        assign nxt = (cmd.rotate && cnt_q == CNT_W'(g + 1)) ? ent[0] : ent[g+1];
      end
      if (g == 0) begin : g_p0
        assign past[g] = 1'b0;
      end else begin : g_p
        assign past[g] = past[g-1] | hit_q[g-1];
      end
      scs_cell u_cell (
        .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .prev_i(prv), .next_i(nxt),
        .past_hit_i(past[g]), .hit_i(hit_q[g]), .key_row_i(pr), .key_col_i(pc),
        .match_o(match[g]), .entry_o(ent[g])
      );
    end
  endgenerate

  logic [CAPACITY-1:0] live;
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) live[i] = CNT_W'(i) < cnt_q;
  end

  // Coordinates are unique among live entries, so at most one bit is set.
  logic [CAPACITY-1:0] hit_now;
  assign hit_now = match & live;

  logic [CW-1:0] rl, cl, rlc, clc;
  assign rl  = CW'(trans_q ? clim_cfg_q : rlim_cfg_q);
  assign cl  = CW'(trans_q ? rlim_cfg_q : clim_cfg_q);
  assign rlc = (rl > MAXD) ? MAXD : rl;
  assign clc = (cl > MAXD) ? MAXD : cl;
  logic in_range;
  assign in_range = (CW'(r_q) < rlc) && (CW'(c_q) < clc);

  logic [VAL_W-1:0] xs, sum;
  assign xs  = (act_q == ACT_SUB) ? (VAL_W'(0) - x_q) : x_q;
  assign sum = hit_ent_q.val + xs;
  logic full;
  assign full = cnt_q == CNT_W'(CAPACITY);

  // Cell command: a dump rotation moves the live chain one cell toward the
  // head while the head entry wraps to the last live cell, so the head always
  // holds the next entry to report and cnt rotations restore the order. Dead
  // cells past the count also shift, which is harmless since they are never
  // read.
  always_comb begin
    cmd = '0;
    cmd.head = '{row: pr, col: pc, val: found_q ? sum : xs};
    if (act_q == ACT_INS) cmd.head.val = x_q;
    if (state_q == S_DUMP && (!ov_q || m_axis_tready) && dump_left_q != '0) begin
      cmd.rotate = 1'b1;
    end
    if (state_q == S_EXEC && in_range) begin
      case (act_q)
        ACT_INS: cmd.shift_in = !found_q && !full;
        ACT_ADD, ACT_SUB: begin
          if (found_q) begin
            cmd.remove = sum == '0;
            cmd.update = sum != '0;
          end else begin
            cmd.shift_in = (xs != '0) && !full;
          end
        end
        default: ;
      endcase
    end
  end

  logic in_acc, out_acc, out_load;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign out_load = cmd.rotate || (state_q == S_OUT && (!ov_q || m_axis_tready));
  assign cfg_ready_o = 1'b1;

  // The matched entry is captured in the compare cycle, so sum is valid when
  // the cell command is issued.
  entry_t hit_sel;
  always_comb begin
    hit_sel = ent[0];
    for (int i = 0; i < CAPACITY; i++) if (hit_now[i]) hit_sel = ent[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0; trans_q <= 1'b0; ov_q <= 1'b0;
      rlim_cfg_q <= LIM_W'(256); clim_cfg_q <= LIM_W'(256);
      dump_left_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_ROW) rlim_cfg_q <= cfg_data_i;
        else clim_cfg_q <= cfg_data_i;
      end
      if (out_acc && !out_load) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_acc) begin
          act_q <= s_axis_tdata[2:0];
          r_q   <= s_axis_tdata[10:3];
          c_q   <= s_axis_tdata[18:11];
          x_q   <= s_axis_tdata[50:19];
          state_q <= S_CMP;
        end
        S_CMP: begin
          hit_q <= hit_now;
          found_q <= |hit_now;
          hit_ent_q <= hit_sel;
          state_q <= (act_q == ACT_DUMP && cnt_q != '0) ? S_DUMP : S_EXEC;
          dump_left_q <= cnt_q;
        end
        S_EXEC: begin
          state_q <= S_OUT;
        end
        S_OUT: if (!ov_q || m_axis_tready) begin
          ov_q <= 1'b1; olast_q <= 1'b1;
          orow_q <= '0; ocol_q <= '0; oval_q <= '0; ost_q <= ST_OK;
          state_q <= S_IDLE;
          case (act_q)
            ACT_CLEAR: cnt_q <= '0;
            ACT_TRANS: trans_q <= !trans_q;
            ACT_DUMP:  ost_q <= ST_NOTFOUND;
            ACT_INS, ACT_ADD, ACT_SUB, ACT_LOOK: begin
              orow_q <= r_q; ocol_q <= c_q;
              if (!in_range) ost_q <= ST_RANGE;
              else if (act_q == ACT_LOOK) begin
                if (found_q) oval_q <= hit_ent_q.val; else ost_q <= ST_NOTFOUND;
              end else if (act_q == ACT_INS) begin
                if (found_q) begin ost_q <= ST_PRESENT; oval_q <= hit_ent_q.val; end
                else if (full) ost_q <= ST_FULL;
                else begin oval_q <= x_q; cnt_q <= cnt_q + 1'b1; end
              end else if (found_q) begin
                oval_q <= sum;
                if (sum == '0) cnt_q <= cnt_q - 1'b1;
              end else if (xs == '0) begin
              end else if (full) ost_q <= ST_FULL;
              else begin oval_q <= xs; cnt_q <= cnt_q + 1'b1; end
            end
            default: ost_q <= ST_RANGE;
          endcase
        end
        S_DUMP: begin
          if (cmd.rotate) begin
            ov_q <= 1'b1; ost_q <= ST_OK;
            orow_q <= trans_q ? ent[0].col : ent[0].row;
            ocol_q <= trans_q ? ent[0].row : ent[0].col;
            oval_q <= ent[0].val;
            olast_q <= dump_left_q == CNT_W'(1);
            dump_left_q <= dump_left_q - 1'b1;
          end else if (dump_left_q == '0 && (!ov_q || m_axis_tready)) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {5'd0, oval_q, ocol_q, orow_q, ost_q};

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY)) else $error("entry count over capacity");
  a_hit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |-> $onehot0(hit_q)) else $error("multiple hits");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !s_axis_tready) else $error("accept while busy");
`endif
endmodule

// File: rtl/scs_cell.sv
// ----------------------------------------------------------------------------
// scs_cell: one storage cell of the coordinate chain
// Holds one entry, compares it with the probe key and shifts with neighbors.
// ----------------------------------------------------------------------------
module scs_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  scs_pkg::cell_cmd_t      cmd_i,
  input  scs_pkg::entry_t         prev_i,   // neighbor toward head
  input  scs_pkg::entry_t         next_i,   // neighbor toward tail
  input  logic                    past_hit_i, // a cell nearer the head matched
  input  logic                    hit_i,
  input  logic [scs_pkg::IDX_W-1:0] key_row_i,
  input  logic [scs_pkg::IDX_W-1:0] key_col_i,
  output logic                    match_o,
  output scs_pkg::entry_t         entry_o
);
  import scs_pkg::*;

  entry_t ent_q, ent_d;

  assign match_o = (ent_q.row == key_row_i) && (ent_q.col == key_col_i);
  assign entry_o = ent_q;

  // A push moves entries toward the tail; a dump rotation moves them toward
  // the head, with the head entry wrapping around to the last live cell.
  always_comb begin
    ent_d = ent_q;
    if (cmd_i.shift_in) begin
      ent_d = prev_i;
    end else if (cmd_i.rotate) begin
      ent_d = next_i;
    end else if (cmd_i.remove && (past_hit_i || hit_i)) begin
      ent_d = next_i;
    end else if (cmd_i.update && hit_i) begin
      ent_d.val = cmd_i.head.val;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  logic unused_rst;
  assign unused_rst = rst_ni;
endmodule

// File: sim/sparse_coordinate_store_tb.sv
// ----------------------------------------------------------------------------
// sparse_coordinate_store_tb: self-checking bench for the coordinate store
// A directed table followed by random traffic. A behavioral copy of the store
// predicts every result, and each one is compared when the output takes it.
// ----------------------------------------------------------------------------
module sparse_coordinate_store_tb;
  import scs_pkg::*;

  localparam int unsigned CAP = 64;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam logic [2:0] ACT_UNUSED = 3'd7;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [31:0] val;
    logic        last;
  } result_t;

  typedef struct {
    logic [2:0]  act;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [31:0] val;
    bit          has_exp;
    result_t     exp;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [LIM_W-1:0] cfg_data_i = '0;

  sparse_coordinate_store dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Behavioral copy of the store.
  logic [7:0]  mat_rows[CAP];
  logic [7:0]  mat_cols[CAP];
  logic [31:0] mat_vals[CAP];
  int unsigned mat_count = 0;
  bit          mat_transposed = 1'b0;
  logic [8:0]  lim_rows = 9'd256;
  logic [8:0]  lim_cols = 9'd256;

  result_t pending_results[$];
  int  errors = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  recv_hold = 1'b0;
  int  quiet_cycles = 0;

  function automatic logic [8:0] clamp_lim(logic [8:0] l);
    return (l > 9'd256) ? 9'd256 : l;
  endfunction

  function automatic int find_coord(logic [7:0] pr, logic [7:0] pc);
    for (int i = 0; i < mat_count; i++)
      if (mat_rows[i] == pr && mat_cols[i] == pc) return i;
    return -1;
  endfunction

  function automatic result_t mk(logic [2:0] st, logic [7:0] r, logic [7:0] c,
                                 logic [31:0] v, logic l);
    result_t x;
    x.status = st; x.row = r; x.col = c; x.val = v; x.last = l;
    return x;
  endfunction

  // Applies one action to the copy and queues the results it produces.
  task automatic predict_action(logic [2:0] act, logic [7:0] r, logic [7:0] c,
                                logic [31:0] v);
    logic [8:0]  rlim;
    logic [8:0]  clim;
    logic [7:0]  pr;
    logic [7:0]  pc;
    logic [31:0] x;
    logic [31:0] sum;
    int idx;
    rlim = clamp_lim(mat_transposed ? lim_cols : lim_rows);
    clim = clamp_lim(mat_transposed ? lim_rows : lim_cols);
    pr = mat_transposed ? c : r;
    pc = mat_transposed ? r : c;
    x = v;
    case (act)
      ACT_CLEAR: begin
        mat_count = 0;
        pending_results.push_back(mk(ST_OK, 0, 0, 0, 1));
      end
      ACT_TRANS: begin
        mat_transposed = !mat_transposed;
        pending_results.push_back(mk(ST_OK, 0, 0, 0, 1));
      end
      ACT_DUMP: begin
        if (mat_count == 0) pending_results.push_back(mk(ST_NOTFOUND, 0, 0, 0, 1));
        for (int i = mat_count - 1; i >= 0; i--)
          pending_results.push_back(mk(ST_OK,
            mat_transposed ? mat_cols[i] : mat_rows[i],
            mat_transposed ? mat_rows[i] : mat_cols[i], mat_vals[i], i == 0));
      end
      ACT_UNUSED: pending_results.push_back(mk(ST_RANGE, 0, 0, 0, 1));
      default: begin
        if ({1'b0, r} >= rlim || {1'b0, c} >= clim) begin
          pending_results.push_back(mk(ST_RANGE, r, c, 0, 1));
        end else begin
          idx = find_coord(pr, pc);
          if (act == ACT_LOOK) begin
            if (idx < 0) pending_results.push_back(mk(ST_NOTFOUND, r, c, 0, 1));
            else pending_results.push_back(mk(ST_OK, r, c, mat_vals[idx], 1));
          end else if (act == ACT_INS) begin
            if (idx >= 0) pending_results.push_back(mk(ST_PRESENT, r, c, mat_vals[idx], 1));
            else if (mat_count >= CAP) pending_results.push_back(mk(ST_FULL, r, c, 0, 1));
            else begin
              mat_rows[mat_count] = pr; mat_cols[mat_count] = pc;
              mat_vals[mat_count] = x; mat_count++;
              pending_results.push_back(mk(ST_OK, r, c, x, 1));
            end
          end else begin
            if (act == ACT_SUB) x = -x;
            if (idx >= 0) begin
              sum = mat_vals[idx] + x;
              if (sum == 0) begin
                for (int i = idx; i < mat_count - 1; i++) begin
                  mat_rows[i] = mat_rows[i+1]; mat_cols[i] = mat_cols[i+1];
                  mat_vals[i] = mat_vals[i+1];
                end
                mat_count--;
              end else mat_vals[idx] = sum;
              pending_results.push_back(mk(ST_OK, r, c, sum, 1));
            end else if (x == 0) pending_results.push_back(mk(ST_OK, r, c, 0, 1));
            else if (mat_count >= CAP) pending_results.push_back(mk(ST_FULL, r, c, 0, 1));
            else begin
              mat_rows[mat_count] = pr; mat_cols[mat_count] = pc;
              mat_vals[mat_count] = x; mat_count++;
              pending_results.push_back(mk(ST_OK, r, c, x, 1));
            end
          end
        end
      end
    endcase
  endtask

  // Output side: receiver stalls and result checking.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        result_t got;
        result_t want;
        got = mk(m_axis_tdata[2:0], m_axis_tdata[10:3], m_axis_tdata[18:11],
                 m_axis_tdata[50:19], m_axis_tlast);
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: %p", got);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status); errors++;
          end
          if (got.row != want.row) begin
            $error("out_row: expected %0d, got %0d", want.row, got.row); errors++;
          end
          if (got.col != want.col) begin
            $error("out_column: expected %0d, got %0d", want.col, got.col); errors++;
          end
          if (got.val != want.val) begin
            $error("out_value: expected %0h, got %0h", want.val, got.val); errors++;
          end
          if (got.last != want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last); errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** sparse_coordinate_store: FAILED **");
      $finish;
    end
  end

  // Valid stays high after a transfer so that items can follow back to back;
  // whoever pauses the sender drops it.
  task automatic send_item(logic [2:0] act, logic [7:0] r, logic [7:0] c,
                           logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, v, c, r, act};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_action(act, r, c, v);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(logic idx, logic [8:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_ROW) lim_rows = val; else lim_cols = val;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random item, mostly within a small coordinate window so hits happen.
  task automatic send_random(logic [8:0] span);
    logic [2:0] act;
    logic [7:0] r;
    logic [7:0] c;
    logic [31:0] v;
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) act = ACT_INS;
    else if (pick < 45) act = ACT_ADD;
    else if (pick < 60) act = ACT_SUB;
    else if (pick < 78) act = ACT_LOOK;
    else if (pick < 84) act = ACT_TRANS;
    else if (pick < 90) act = ACT_DUMP;
    else if (pick < 93) act = ACT_CLEAR;
    else if (pick < 95) act = ACT_UNUSED;
    else act = ACT_INS;
    if ($urandom_range(9) == 0) begin
      r = 8'($urandom); c = 8'($urandom);
    end else begin
      r = 8'($urandom_range(span - 1)); c = 8'($urandom_range(span - 1));
    end
    case ($urandom_range(3))
      0: v = $urandom_range(3);
      1: v = -$urandom_range(3);
      default: v = $urandom;
    endcase
    send_item(act, r, c, v);
  endtask

  stim_row_t directed[$];

  task automatic add_row(logic [2:0] a, logic [7:0] r, logic [7:0] c, logic [31:0] v,
                         bit he, result_t e);
    stim_row_t s;
    s.act = a; s.row = r; s.col = c; s.val = v; s.has_exp = he; s.exp = e;
    directed.push_back(s);
  endtask

  initial begin
    int phase_items;
    result_t nil;
    nil = '0;
    add_row(ACT_DUMP, 0, 0, 0, 1, mk(ST_NOTFOUND, 0, 0, 0, 1));
    add_row(ACT_LOOK, 255, 255, 0, 1, mk(ST_NOTFOUND, 255, 255, 0, 1));
    add_row(ACT_INS, 0, 0, 32'h7fffffff, 1, mk(ST_OK, 0, 0, 32'h7fffffff, 1));
    add_row(ACT_INS, 0, 0, 5, 1, mk(ST_PRESENT, 0, 0, 32'h7fffffff, 1));
    add_row(ACT_INS, 255, 1, 32'h80000000, 1, mk(ST_OK, 255, 1, 32'h80000000, 1));
    add_row(ACT_ADD, 0, 0, 1, 0, nil);
    add_row(ACT_SUB, 255, 1, 32'h80000000, 0, nil);
    add_row(ACT_ADD, 9, 9, 0, 1, mk(ST_OK, 9, 9, 0, 1));
    add_row(ACT_ADD, 3, 4, 32'hffffffff, 0, nil);
    add_row(ACT_SUB, 3, 4, 32'hffffffff, 1, mk(ST_OK, 3, 4, 0, 1));
    add_row(ACT_SUB, 7, 200, 12, 0, nil);
    add_row(ACT_DUMP, 0, 0, 0, 0, nil);
    add_row(ACT_TRANS, 0, 0, 0, 1, mk(ST_OK, 0, 0, 0, 1));
    add_row(ACT_LOOK, 200, 7, 0, 0, nil);
    add_row(ACT_DUMP, 0, 0, 0, 0, nil);
    add_row(ACT_TRANS, 0, 0, 0, 1, mk(ST_OK, 0, 0, 0, 1));
    add_row(ACT_UNUSED, 8'hff, 8'hff, 32'hffffffff, 1, mk(ST_RANGE, 0, 0, 0, 1));
    add_row(ACT_CLEAR, 0, 0, 0, 1, mk(ST_OK, 0, 0, 0, 1));
    add_row(ACT_DUMP, 0, 0, 0, 1, mk(ST_NOTFOUND, 0, 0, 0, 1));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      send_item(directed[i].act, directed[i].row, directed[i].col, directed[i].val);
      if (directed[i].has_exp && pending_results[$] != directed[i].exp) begin
        $error("table row %0d: expected %p, got prediction %p", i,
               directed[i].exp, pending_results[$]);
        errors++;
      end
    end
    wait_drained();

    // Small limits: range errors, on both axes and under transpose.
    write_limit(CFG_ROW, 9'd1);
    write_limit(CFG_COL, 9'd3);
    send_item(ACT_INS, 0, 2, 11);
    send_item(ACT_INS, 1, 0, 11);
    send_item(ACT_INS, 0, 3, 11);
    send_item(ACT_TRANS, 0, 0, 0);
    send_item(ACT_LOOK, 2, 0, 0);
    send_item(ACT_LOOK, 0, 1, 0);
    send_item(ACT_TRANS, 0, 0, 0);
    wait_drained();
    write_limit(CFG_ROW, 9'h1ff);
    write_limit(CFG_COL, 9'h1ff);
    send_item(ACT_LOOK, 8'hff, 8'hff, 0);

    // Fill the store to capacity, then hit the full cases.
    for (int i = 0; i < CAP; i++) send_item(ACT_INS, 8'(i), 8'(i) ^ 8'h5a, $urandom | 1);
    send_item(ACT_INS, 100, 100, 1);
    send_item(ACT_ADD, 100, 101, 2);
    send_item(ACT_ADD, 100, 101, 0);
    send_item(ACT_DUMP, 0, 0, 0);
    // Long receiver stall while the sender keeps offering.
    recv_hold = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      begin
        for (int i = 0; i < 12; i++) send_item(ACT_LOOK, 8'(i), 8'(i) ^ 8'h5a, 0);
        s_axis_tvalid <= 1'b0;
      end
    join
    wait_drained();
    send_item(ACT_CLEAR, 0, 0, 0);
    wait_drained();

    // Random phases with different idling and limits.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 49 : 0;
      recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 27 : 0;
      write_limit(CFG_ROW, (ph == 1) ? 9'd5 : 9'd256);
      write_limit(CFG_COL, (ph == 1) ? 9'd2 : 9'd200);
      phase_items = 17;
      for (int i = 0; i < phase_items; i++) begin
        send_random((ph == 1) ? 9'd6 : 9'd8);
        if (i == 8) wait_drained();
      end
      wait_drained();
    end
    send_item(ACT_DUMP, 0, 0, 0);
    wait_drained();
    repeat (20) @(posedge clk_i);

    if (errors == 0 && pending_results.size() == 0)
      $display("** sparse_coordinate_store: PASSED **");
    else
      $display("** sparse_coordinate_store: FAILED **");
    $finish;
  end
endmodule

// File: sim.f
rtl/scs_pkg.sv
rtl/scs_cell.sv
rtl/sparse_coordinate_store.sv
sim/sparse_coordinate_store_tb.sv
